// ===== hw/rtl/ncpm_pkg.sv =====
// shared constants, register indexes and types for the nibble class pattern matcher
package ncpm_pkg;

    // sizes fixed by the stream and register formats
    localparam int MAX_PATTERN_DEF = 8;
    localparam int LEN_W           = 4;
    localparam int POS_W           = 48;
    localparam int SET_W           = 16;
    localparam int NIB_W           = 4;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int OUT_DATA_W      = 56;
    localparam int SET_ALL_W       = 2 * CFG_DATA_W;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_SECOND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RES_LIMIT   = 3'd6;

    // register file contents as seen by the datapath
    typedef struct packed {
        logic [SET_ALL_W-1:0] high_sets;
        logic [SET_ALL_W-1:0] low_sets;
        logic [LEN_W-1:0]     pattern_length;
        logic [POS_W-1:0]     first_offset;
        logic [POS_W-1:0]     result_limit;
    } t_cfg;

    // per-word control broadcast to every cell
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  len;
        logic              advance;
        logic              clear;
    } t_step;

endpackage

// ===== hw/rtl/ncpm_cfg.sv =====
// configuration register file for the nibble class pattern matcher
module ncpm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ncpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ncpm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ncpm_pkg::t_cfg                   o_cfg
);
    import ncpm_pkg::*;

    logic [CFG_DATA_W-1:0] r_high_first;
    logic [CFG_DATA_W-1:0] r_high_second;
    logic [CFG_DATA_W-1:0] r_low_first;
    logic [CFG_DATA_W-1:0] r_low_second;
    logic [LEN_W-1:0]      r_pat_len;
    logic [POS_W-1:0]      r_first_ofs;
    logic [POS_W-1:0]      r_res_limit;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register write decode, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_first  <= '0;
            r_high_second <= '0;
            r_low_first   <= '0;
            r_low_second  <= '0;
            r_pat_len     <= '0;
            r_first_ofs   <= '0;
            r_res_limit   <= POS_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HIGH_FIRST:  r_high_first  <= i_cfg_data;
                REG_HIGH_SECOND: r_high_second <= i_cfg_data;
                REG_LOW_FIRST:   r_low_first   <= i_cfg_data;
                REG_LOW_SECOND:  r_low_second  <= i_cfg_data;
                REG_PAT_LEN:     r_pat_len     <= i_cfg_data[LEN_W-1:0];
                REG_FIRST_OFS:   r_first_ofs   <= i_cfg_data[POS_W-1:0];
                REG_RES_LIMIT:   r_res_limit   <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.high_sets      = {r_high_second, r_high_first};
    assign o_cfg.low_sets       = {r_low_second, r_low_first};
    assign o_cfg.pattern_length = r_pat_len;
    assign o_cfg.first_offset   = r_first_ofs;
    assign o_cfg.result_limit   = r_res_limit;

endmodule

// ===== hw/rtl/ncpm_cell.sv =====
// one pattern position: nibble class test and one bit of the shift-and vector
module ncpm_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ncpm_pkg::t_step             i_step,
    input  logic                        i_prev,
    input  logic [ncpm_pkg::SET_W-1:0]  i_hi_set,
    input  logic [ncpm_pkg::SET_W-1:0]  i_lo_set,
    output logic                        o_bit,
    output logic                        o_tail
);
    import ncpm_pkg::*;

    logic [NIB_W-1:0] hi_nib;
    logic [NIB_W-1:0] lo_nib;
    logic             in_use;
    logic             allow;
    logic             n_bit;
    logic             r_bit;

    // class test on both nibbles, only for positions inside the pattern
    assign hi_nib = i_step.data_byte[BYTE_W-1:NIB_W];
    assign lo_nib = i_step.data_byte[NIB_W-1:0];
    assign in_use = i_step.len > LEN_W'(IDX);
    assign allow  = in_use & i_hi_set[hi_nib] & i_lo_set[lo_nib];

    // prefix ending here extends the neighbour's prefix by one byte
    assign n_bit  = i_prev & allow;

    // whole pattern ends at this byte when this is the final position
    assign o_tail = n_bit & (i_step.len == LEN_W'(IDX + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_step.advance) begin
            r_bit <= i_step.clear ? 1'b0 : n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// ===== hw/rtl/nibble_class_pattern_matcher.sv =====
// top level of the nibble class pattern matcher: cell row, counters and result register
//
// channel  direction  handshake                    payload
// s        in         i_s_tvalid / o_s_tready      i_s_tdata (byte), i_s_tlast (end of buffer)
// m        out        o_m_tvalid / i_m_tready      o_m_tdata (offset, length)
// cfg      in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one byte per cycle unless stalled; a match reaches m the cycle after its final byte is taken
// the byte is classified and the whole shift-and update done in the cell row
// reset clears the vector, position, count and result register; registers take their defaults
// a stalled result stops byte intake only while the result register is full and not taken
module nibble_class_pattern_matcher #(
    parameter int MAX_PATTERN = ncpm_pkg::MAX_PATTERN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // data_byte[7:0]
    input  logic [ncpm_pkg::BYTE_W-1:0]        i_s_tdata,
    input  logic                               i_s_tlast,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // match_offset[47:0], match_length[51:48], zero[55:52]
    output logic [ncpm_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ncpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ncpm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ncpm_pkg::*;

    t_cfg                   cfg;
    t_step                  step;
    logic                   step_accept;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       len_m1;
    logic [MAX_PATTERN-1:0] vec_bits;
    logic [MAX_PATTERN-1:0] tails;
    logic                   hit;
    logic [POS_W-1:0]       start_ofs;
    logic                   report;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic [POS_W-1:0]       r_count;
    logic [POS_W-1:0]       n_count;
    logic                   r_out_valid;
    logic [POS_W-1:0]       r_out_ofs;
    logic [LEN_W-1:0]       r_out_len;

    // register file
    ncpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // handshake: take a word unless a result is stuck in the output register
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign step_accept = i_s_tvalid && o_s_tready;

    // clamp the pattern length to the cells present
    assign len_eff = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : cfg.pattern_length;

    assign step.data_byte = i_s_tdata;
    assign step.len       = len_eff;
    assign step.advance   = step_accept;
    assign step.clear     = i_s_tlast;

    // row of cells, each fed by its left neighbour's stored bit; the first cell is fed a constant one
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic prev;
        if (j == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_link
            assign prev = vec_bits[j-1];
        end
        ncpm_cell #(.IDX(j)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (step),
            .i_prev   (prev),
            .i_hi_set (cfg.high_sets[SET_W*j +: SET_W]),
            .i_lo_set (cfg.low_sets[SET_W*j +: SET_W]),
            .o_bit    (vec_bits[j]),
            .o_tail   (tails[j])
        );
    end

    // full match check against offset window and result budget
    assign hit       = |tails;
    assign len_m1    = len_eff - LEN_W'(1);
    assign start_ofs = r_pos - POS_W'(len_m1);
    assign report    = hit && (r_pos >= POS_W'(len_m1))
                       && (start_ofs >= cfg.first_offset)
                       && (r_count < cfg.result_limit);

    // position saturates, both counters clear after the end of buffer
    assign n_pos   = i_s_tlast ? '0 : ((r_pos != POS_MAX) ? r_pos + POS_W'(1) : r_pos);
    assign n_count = i_s_tlast ? '0 : r_count + POS_W'(report);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
        end else if (step_accept) begin
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_accept && report) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_accept && report) begin
            r_out_ofs <= start_ofs;
            r_out_len <= len_eff;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - POS_W - LEN_W){1'b0}}, r_out_len, r_out_ofs};

`ifndef NO_ASSERTIONS
    // a reported match is always presented on the next cycle
    a_report_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_accept && report |=> o_m_tvalid)
        else $error("reported match not presented");

    // end of buffer leaves clean stream state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_accept && i_s_tlast |=> (r_pos == '0) && (r_count == '0) && (vec_bits == '0))
        else $error("stream state not cleared after end of buffer");

    // no intake while a result is held back
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("byte taken while result stalled");

    // a presented match never has zero length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_len != '0))
        else $error("match with zero length");
`endif

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the nibble class pattern matcher
module tb;
    import ncpm_pkg::*;

    localparam int                   CLK_HALF    = 10;
    localparam int                   HOLD_CYCLES = 300;
    localparam int                   DRAIN_LIMIT = 5000;
    localparam int                   RAND_PHASES = 20;
    localparam int                   PHASE_ITEMS = 55;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;

    // one expected match
    typedef struct {
        logic [POS_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_match;

    // shift-and predictor with its own register copy and a queue of matches still to come
    class match_tracker;
        logic [CFG_DATA_W-1:0] high_first, high_second, low_first, low_second;
        logic [LEN_W-1:0]      pat_len;
        logic [POS_W-1:0]      first_ofs, res_limit;
        logic [7:0]            vec;
        logic [POS_W-1:0]      pos, count;
        t_match                pending_matches[$];
        int                    fails, bytes_seen, matches_seen, writes_seen;

        function new();
            high_first  = '0;
            high_second = '0;
            low_first   = '0;
            low_second  = '0;
            pat_len     = '0;
            first_ofs   = '0;
            res_limit   = POS_MAX;
            vec         = '0;
            pos         = '0;
            count       = '0;
            fails        = 0;
            bytes_seen   = 0;
            matches_seen = 0;
            writes_seen  = 0;
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            fails++;
        endfunction

        function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            writes_seen++;
            case (idx)
                REG_HIGH_FIRST:  high_first  = val;
                REG_HIGH_SECOND: high_second = val;
                REG_LOW_FIRST:   low_first   = val;
                REG_LOW_SECOND:  low_second  = val;
                REG_PAT_LEN:     pat_len     = val[LEN_W-1:0];
                REG_FIRST_OFS:   first_ofs   = val[POS_W-1:0];
                REG_RES_LIMIT:   res_limit   = val[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // one step of the shift-and search for an accepted byte
        function void take_byte(logic [7:0] b, logic last);
            int unsigned           len;
            logic [7:0]            allow;
            logic [CFG_DATA_W-1:0] hw, lw;
            logic [SET_W-1:0]      hs, ls;
            t_match                m;
            bytes_seen++;
            len = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len;
            allow = '0;
            for (int j = 0; j < len; j++) begin
                hw = (j < 4) ? high_first : high_second;
                lw = (j < 4) ? low_first : low_second;
                hs = hw[SET_W*(j%4) +: SET_W];
                ls = lw[SET_W*(j%4) +: SET_W];
                if (hs[b[7:4]] && ls[b[3:0]]) allow[j] = 1'b1;
            end
            vec = ((vec << 1) | 8'h01) & allow;
            if (len > 0 && vec[len-1] && pos >= POS_W'(len - 1)) begin
                m.offset = pos - POS_W'(len - 1);
                m.length = LEN_W'(len);
                if (m.offset >= first_ofs && count < res_limit) begin
                    pending_matches.insert(pending_matches.size(), m);
                    count = count + 1'b1;
                end
            end
            if (pos != POS_MAX) pos = pos + 1'b1;
            if (last) begin
                vec   = '0;
                pos   = '0;
                count = '0;
            end
        endfunction

        function void check_match(logic [OUT_DATA_W-1:0] word);
            t_match m;
            matches_seen++;
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("unexpected match word %h", word));
            end else begin
                m = pending_matches.pop_front();
                if (word[POS_W-1:0] !== m.offset)
                    report_mismatch($sformatf("offset %0d, expected %0d",
                                              word[POS_W-1:0], m.offset));
                if (word[POS_W +: LEN_W] !== m.length)
                    report_mismatch($sformatf("length %0d, expected %0d",
                                              word[POS_W +: LEN_W], m.length));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic [BYTE_W-1:0]     i_s_tdata;
    logic                  i_s_tlast;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    match_tracker sb;
    bit           tx_fast;
    bit           rx_fast;
    bit           hold_req;
    int           settings_run;
    logic [7:0]   target_bytes [MAX_PATTERN_DEF];

    nibble_class_pattern_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(2 * CLK_HALF * 500000);
        $display("FAIL");
        $finish;
    end

    // sample every handshake at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_match(o_m_tdata);
            if (i_s_tvalid && o_s_tready) sb.take_byte(i_s_tdata, i_s_tlast);
            if (i_cfg_valid && o_cfg_ready) sb.take_config(i_cfg_index, i_cfg_data);
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                @(negedge i_clk) i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = rx_fast ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                @(negedge i_clk) i_m_tready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // offer one byte, keeping valid high across back-to-back words
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            @(negedge i_clk) i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tlast  = last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid = 1'b0;
    endtask

    // stop offering and let every pending match drain
    task automatic wait_idle();
        @(negedge i_clk) i_s_tvalid = 1'b0;
        while (sb.pending_matches.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] hf, input logic [CFG_DATA_W-1:0] hs,
                             input logic [CFG_DATA_W-1:0] lf, input logic [CFG_DATA_W-1:0] ls,
                             input logic [CFG_DATA_W-1:0] len, input logic [CFG_DATA_W-1:0] ofs,
                             input logic [CFG_DATA_W-1:0] lim);
        write_reg(REG_HIGH_FIRST, hf);
        write_reg(REG_HIGH_SECOND, hs);
        write_reg(REG_LOW_FIRST, lf);
        write_reg(REG_LOW_SECOND, ls);
        write_reg(REG_PAT_LEN, len);
        write_reg(REG_FIRST_OFS, ofs);
        write_reg(REG_RES_LIMIT, lim);
        settings_run++;
    endtask

    function automatic logic [SET_W-1:0] make_set(input logic [NIB_W-1:0] want);
        logic [SET_W-1:0] s;
        s = SET_W'(1) << want;
        case ($urandom_range(0, 15))
            0:       s = '0;
            1, 2:    s = '1;
            3, 4, 5: s = s | SET_W'($urandom);
            6, 7, 8: s = s | SET_W'($urandom & $urandom);
            default: ;
        endcase
        return s;
    endfunction

    // one random register setting followed by a batch of streams
    task automatic run_random_phase(input int items);
        logic [CFG_DATA_W-1:0] hw [2];
        logic [CFG_DATA_W-1:0] lw [2];
        logic [3:0]            len;
        logic [POS_W-1:0]      ofs, lim;
        logic [7:0]            b;
        int                    eff, sent, slen, rp;
        bit                    leave_open;
        for (int j = 0; j < MAX_PATTERN_DEF; j++) begin
            target_bytes[j] = 8'($urandom);
            hw[j/4][SET_W*(j%4) +: SET_W] = make_set(target_bytes[j][7:4]);
            lw[j/4][SET_W*(j%4) +: SET_W] = make_set(target_bytes[j][3:0]);
        end
        case ($urandom_range(0, 15))
            0:              len = 4'd0;
            11, 12:         len = 4'($urandom_range(5, 8));
            13:             len = 4'd8;
            14, 15:         len = 4'($urandom_range(9, 15));
            default:        len = 4'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 7))
            4, 5:    ofs = POS_W'($urandom_range(0, 30));
            6:       ofs = POS_W'({$urandom, $urandom});
            7:       ofs = POS_MAX;
            default: ofs = '0;
        endcase
        case ($urandom_range(0, 7))
            4:       lim = '0;
            5, 6:    lim = POS_W'($urandom_range(1, 6));
            7:       lim = POS_W'({$urandom, $urandom});
            default: lim = POS_MAX;
        endcase
        write_all(hw[0], hw[1], lw[0], lw[1], {$urandom, 28'($urandom), len},
                  {16'($urandom), ofs}, {16'($urandom), lim});
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
        leave_open = ($urandom_range(0, 3) == 0);
        eff = (len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : ((len == 0) ? 1 : len);
        sent = 0;
        while (sent < items) begin
            slen = $urandom_range(1, 40);
            if (sent + slen > items) slen = items - sent;
            rp = 0;
            for (int k = 0; k < slen; k++) begin
                // mostly well-formed pattern runs, with noise and broken runs
                if ($urandom_range(0, 3) != 0) begin
                    b = target_bytes[rp];
                    if ($urandom_range(0, 15) == 0) b = 8'($urandom);
                    rp = (rp + 1) % eff;
                end else begin
                    b = 8'($urandom);
                    rp = 0;
                end
                send_byte(b, (k == slen - 1) && !(leave_open && sent + slen == items));
            end
            sent += slen;
        end
        wait_idle();
    endtask

    // stimulus
    initial begin
        int drain;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tx_fast      = 1'b0;
        rx_fast      = 1'b0;
        hold_req     = 1'b0;
        settings_run = 0;
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults after reset: zero length never matches
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();

        // two-position pattern F0 0F
        write_all(64'h0000_0000_0001_8000, '0, 64'h0000_0000_8000_0001, '0,
                  64'd2, 64'd0, {16'h0, POS_MAX});
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();

        // start offset skips the first window, limit of one stops the third
        write_reg(REG_FIRST_OFS, 64'd2);
        write_reg(REG_RES_LIMIT, 64'd1);
        for (int k = 0; k < 6; k++) send_byte((k % 2) ? 8'h0F : 8'hF0, k == 5);
        wait_idle();

        // zero limit, and a write to the unused index that must change nothing
        write_reg(REG_RES_LIMIT, 64'd0);
        write_reg(REG_SPARE, '1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b1);
        wait_idle();

        // overlong length acts as eight, then shrinks to three mid-stream
        write_all('1, '1, '1, '1, 64'd15, 64'd0, {16'h0, POS_MAX});
        for (int k = 0; k < 9; k++) send_byte(8'($urandom), 1'b0);
        wait_idle();
        write_reg(REG_PAT_LEN, 64'd3);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_idle();

        // every byte matches while the receiver holds off, so the input stalls
        write_all('1, '1, '1, '1, 64'd1, 64'd0, {16'h0, POS_MAX});
        tx_fast  = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) send_byte(8'($urandom), k == 59);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) run_random_phase(PHASE_ITEMS);

        // drain and settle
        @(negedge i_clk) i_s_tvalid = 1'b0;
        drain = 0;
        while (sb.pending_matches.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (sb.pending_matches.size() != 0)
            sb.report_mismatch($sformatf("%0d matches never arrived",
                                         sb.pending_matches.size()));
        repeat (10) @(posedge i_clk);

        $display("run covered %0d bytes over %0d register settings (%0d register writes)",
                 sb.bytes_seen, settings_run, sb.writes_seen);
        $display("%0d match words checked, %0d mismatches", sb.matches_seen, sb.fails);
        if (sb.fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
